// ----- rtl/pru_pkg.sv -----
package pru_pkg;

  localparam int unsigned MAX_ROW_BYTES = 16384;
  localparam int unsigned COL_W = $clog2(MAX_ROW_BYTES);
  localparam int unsigned ROW_W = 15;
  localparam int unsigned BPP_W = 3;
  localparam int unsigned CNT_W = (COL_W + 1 > ROW_W) ? COL_W + 1 : ROW_W;
  localparam int unsigned HIST_DEPTH = 4;
  localparam int unsigned HIST_W = $clog2(HIST_DEPTH);

  localparam logic [7:0] FILT_NONE  = 8'd0;
  localparam logic [7:0] FILT_SUB   = 8'd1;
  localparam logic [7:0] FILT_UP    = 8'd2;
  localparam logic [7:0] FILT_AVG   = 8'd3;
  localparam logic [7:0] FILT_PAETH = 8'd4;

  typedef enum logic [0:0] {
    CFG_BPP = 1'b0,
    CFG_ROW = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] filtered_byte;
    logic [7:0] filter_kind;
    logic       image_start;
  } item_t;

  typedef struct packed {
    logic [7:0] recon_byte;
    logic       row_last;
  } result_t;

  // Paeth predictor: nearest of left, up, upleft to left + up - upleft
  function automatic logic [7:0] paeth_pick(input logic [7:0] l, input logic [7:0] u,
                                            input logic [7:0] ul);
    logic signed [9:0] p;
    logic signed [9:0] da;
    logic signed [9:0] db;
    logic signed [9:0] dc;
    logic [9:0] pa;
    logic [9:0] pb;
    logic [9:0] pc;
    p  = $signed({2'b00, l}) + $signed({2'b00, u}) - $signed({2'b00, ul});
    da = p - $signed({2'b00, l});
    db = p - $signed({2'b00, u});
    dc = p - $signed({2'b00, ul});
    pa = (da < 0) ? 10'(-da) : 10'(da);
    pb = (db < 0) ? 10'(-db) : 10'(db);
    pc = (dc < 0) ? 10'(-dc) : 10'(dc);
    if (pa <= pb && pa <= pc) begin
      return l;
    end else if (pb <= pc) begin
      return u;
    end else begin
      return ul;
    end
  endfunction

endpackage

// ----- rtl/png_row_unfilter.sv -----
// PNG scanline reconstruction, one byte per transfer.
// item channel: item_valid / item_stall carry a filtered byte, the filter
// type of its row and an image start mark. result channel: result_valid /
// result_stall carry the reconstructed byte and a row end mark.
// cfg channel: cfg_valid / cfg_ready (always ready) writes bytes_per_pixel
// (index 0) or row_bytes (index 1); write only while no byte is in flight.
// Throughput is one byte per cycle while result is not stalled. Each byte
// goes through the compute stage and the output register. The line buffer
// (single write port, registered read) is read at the accept edge and its
// data is used in the next stage, where the byte is rebuilt and written
// back. With one byte rows the previous byte writes that same column as it is read; its result is then forwarded.
// A result stall holds the output register; one more byte is absorbed in
// the compute stage, after which item_stall rises.
// Reset clears the column counter and the pixel histories, sets the first
// row mark and sets both registers to 1. The line buffer is not cleared; the
// first row after image start only writes it.
module png_row_unfilter (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  pru_pkg::item_t    item,
  output logic              result_valid,
  input  logic              result_stall,
  output pru_pkg::result_t  result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  pru_pkg::cfg_reg_t cfg_index,
  input  logic [14:0]       cfg_data
);
  import pru_pkg::*;

  typedef struct packed {
    logic [7:0]       filtered_byte;
    logic [7:0]       filter_kind;
    logic [COL_W-1:0] col;
    logic             first;
    logic             has_left;
    logic             last;
  } stage_t;

  logic [BPP_W-1:0] bytes_per_pixel;
  logic [ROW_W-1:0] row_bytes;

  logic [BPP_W-1:0]  stride;
  logic [HIST_W-1:0] sidx;
  logic [CNT_W-1:0]  rlen;

  logic [COL_W-1:0] column_count;
  logic             on_first_row;

  logic [7:0] line_buf [MAX_ROW_BYTES];
  logic [7:0] rd_data;
  logic       fwd;
  logic [7:0] fwd_data;

  logic [7:0] left_history [HIST_DEPTH];
  logic [7:0] upleft_history [HIST_DEPTH];

  logic   s1_valid;
  stage_t s1;
  logic   s1_adv;
  logic   accept;

  logic [COL_W-1:0] cnt_base;
  logic [COL_W-1:0] col_in;
  logic             first_in;
  logic             last_in;

  logic [7:0] up;
  logic [7:0] left;
  logic [7:0] upleft;
  logic [8:0] lu_sum;
  logic [7:0] pred;
  logic [7:0] res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_per_pixel <= BPP_W'(1);
      row_bytes       <= ROW_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_BPP: bytes_per_pixel <= cfg_data[BPP_W-1:0];
        CFG_ROW: row_bytes       <= cfg_data[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp stride and row length into their working ranges
  always_comb begin
    if (bytes_per_pixel == '0) begin
      stride = BPP_W'(1);
    end else if (bytes_per_pixel > BPP_W'(HIST_DEPTH)) begin
      stride = BPP_W'(HIST_DEPTH);
    end else begin
      stride = bytes_per_pixel;
    end
    sidx = HIST_W'(stride - BPP_W'(1));
    if (row_bytes == '0) begin
      rlen = CNT_W'(1);
    end else if (CNT_W'(row_bytes) > CNT_W'(MAX_ROW_BYTES)) begin
      rlen = CNT_W'(MAX_ROW_BYTES);
    end else begin
      rlen = CNT_W'(row_bytes);
    end
  end

  assign s1_adv     = s1_valid && (!result_valid || !result_stall);
  assign item_stall = s1_valid && !s1_adv;
  assign accept     = item_valid && !item_stall;

  always_comb begin
    cnt_base = item.image_start ? '0 : column_count;
    col_in   = (CNT_W'(cnt_base) >= rlen) ? '0 : cnt_base;
    first_in = item.image_start || on_first_row;
    last_in  = (CNT_W'(col_in) + CNT_W'(1)) == rlen;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      on_first_row <= 1'b1;
    end else if (accept) begin
      if (last_in) begin
        column_count <= '0;
        on_first_row <= 1'b0;
      end else begin
        column_count <= col_in + COL_W'(1);
        on_first_row <= first_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1.filtered_byte <= item.filtered_byte;
      s1.filter_kind   <= item.filter_kind;
      s1.col           <= col_in;
      s1.first         <= first_in;
      s1.has_left      <= CNT_W'(col_in) >= CNT_W'(stride);
      s1.last          <= last_in;
    end
  end

  // Line buffer: write back on advance, read ahead on transfer in
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      line_buf[s1.col] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data  <= line_buf[col_in];
      fwd      <= s1_adv && (s1.col == col_in);
      fwd_data <= res;
    end
  end

  always_comb begin
    up     = s1.first ? 8'd0 : (fwd ? fwd_data : rd_data);
    left   = s1.has_left ? left_history[sidx] : 8'd0;
    upleft = (s1.has_left && !s1.first) ? upleft_history[sidx] : 8'd0;
    lu_sum = {1'b0, left} + {1'b0, up};
    case (s1.filter_kind)
      FILT_NONE:  pred = 8'd0;
      FILT_SUB:   pred = left;
      FILT_UP:    pred = up;
      FILT_AVG:   pred = lu_sum[8:1];
      FILT_PAETH: pred = paeth_pick(left, up, upleft);
      default:    pred = 8'd0;
    endcase
    res = s1.filtered_byte + pred;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < HIST_DEPTH; i++) begin
        left_history[i]   <= 8'd0;
        upleft_history[i] <= 8'd0;
      end
    end else if (s1_adv) begin
      for (int i = HIST_DEPTH - 1; i > 0; i--) begin
        left_history[i]   <= left_history[i-1];
        upleft_history[i] <= upleft_history[i-1];
      end
      left_history[0]   <= res;
      upleft_history[0] <= up;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_adv) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      result.recon_byte <= res;
      result.row_last   <= s1.last;
    end
  end

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> s1_valid && result_valid)
    else $error("item stall raised with room in the pipeline");

  a_advance_fills_output: assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> result_valid)
    else $error("compute stage advanced but no result held");

  a_row_end_wraps: assert property (@(posedge clk) disable iff (rst)
    accept && last_in |=> column_count == '0 && !on_first_row)
    else $error("column counter did not wrap at row end");

  a_col_in_row: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> CNT_W'(s1.col) < rlen)
    else $error("column beyond row length in compute stage");

  a_first_row_kept: assert property (@(posedge clk) disable iff (rst)
    accept && item.image_start && !last_in |=> on_first_row)
    else $error("first row mark lost after image start");

endmodule
